// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    typedef enum logic
    {
        KIND_DATA   = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    // One queued operation between the front and the back part.
    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] data_byte;
    } op_t;

    localparam logic [255:0] INIT_H = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha_queue.sv =====
// ----------------------------------------------------------------------------
// SHA-256 operation queue
// Short queue that decouples input acceptance from block processing.
// ----------------------------------------------------------------------------
module sha_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  sha_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output sha_pkg::op_t head_op,
    output logic         nonempty
);

    sha_pkg::op_t slot_reg [sha_pkg::QUEUE_DEPTH];
    logic [sha_pkg::QPTR_W-1:0] wptr_reg;
    logic [sha_pkg::QPTR_W-1:0] rptr_reg;
    logic [sha_pkg::QPTR_W:0]   count_reg;

    assign full = (count_reg == (sha_pkg::QPTR_W+1)'(sha_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_op = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/sha_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block engine
// Loads bytes into the message schedule, pads on finish, runs the 64 rounds
// and sends the digest out as four 64-bit words.
// ----------------------------------------------------------------------------
module sha_engine
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  sha_pkg::op_t op,
    output logic         op_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  out_word,
    output logic [1:0]   out_index,
    output logic         out_last
);

    typedef enum logic [4:0]
    {
        ST_LOAD  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [5:0]   fill_reg;
    logic [5:0]   round_reg;
    logic [60:0]  msg_bytes_reg;
    logic [63:0]  bit_len_reg;
    logic         finishing_reg;
    logic         len_block_reg;
    logic [1:0]   emit_reg;

    logic [7:0]   load_byte;
    logic         load_now;
    logic [31:0]  sched_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  s0;
    logic [31:0]  s1;

    assign op_pop = (state_reg == ST_LOAD) && op_valid;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word = {h_reg[{emit_reg, 1'b0}], h_reg[{emit_reg, 1'b1}]};
    assign out_index = emit_reg;
    assign out_last = (emit_reg == 2'd3);

    // Bytes of the padding tail: zeros until the length field, then the length.
    // The length goes only into the block that has room for it.
    always_comb
    begin
        load_now = 1'b0;
        load_byte = op.data_byte;
        if (state_reg == ST_LOAD)
        begin
            load_now = op_valid;
            load_byte = (op.kind == sha_pkg::KIND_FINISH) ? sha_pkg::PAD_BYTE
                                                           : op.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            load_now = 1'b1;
            if (len_block_reg && fill_reg >= sha_pkg::LEN_POS)
            begin
                load_byte = bit_len_reg[8*(7 - int'(fill_reg[2:0])) +: 8];
            end
            else
            begin
                load_byte = 8'h00;
            end
        end
    end

    // Schedule word 16 from the sliding window; window slot 0 is w[i].
    assign s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign sched_new = w_reg[0] + s0 + w_reg[9] + s1;

    assign t1 = v_reg[7]
              + (sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                 ^ sha_pkg::rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha_pkg::round_k(round_reg) + w_reg[0];
    assign t2 = (sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
                 ^ sha_pkg::rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge clk)
    begin
        if (load_now)
        begin
            w_reg[fill_reg[5:2]][8*(3 - int'(fill_reg[1:0])) +: 8] <= load_byte;
        end
        if (state_reg == ST_LOAD && op_valid && op.kind == sha_pkg::KIND_FINISH)
        begin
            bit_len_reg <= {msg_bytes_reg, 3'b000};
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= sched_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg <= '0;
            round_reg <= '0;
            msg_bytes_reg <= '0;
            finishing_reg <= 1'b0;
            len_block_reg <= 1'b0;
            emit_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::INIT_H[32*(7-i) +: 32];
            end
        end
        else
        begin
            if (load_now)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (op_valid)
                    begin
                        if (op.kind == sha_pkg::KIND_FINISH)
                        begin
                            finishing_reg <= 1'b1;
                            len_block_reg <= (fill_reg < sha_pkg::LEN_POS);
                        end
                        else
                        begin
                            msg_bytes_reg <= msg_bytes_reg + 1'b1;
                        end
                        if (fill_reg == 6'd63)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (op.kind == sha_pkg::KIND_FINISH)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // Leave when the block is full; a pad byte past 56 with no
                    // room for the length simply rolls into a second block.
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (!finishing_reg)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else if (len_block_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        // The length did not fit, so a second block carries it.
                        state_reg <= ST_PAD;
                        len_block_reg <= 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 2'd3)
                        begin
                            state_reg <= ST_LOAD;
                            finishing_reg <= 1'b0;
                            msg_bytes_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::INIT_H[32*(7-i) +: 32];
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round loop did not end after 64 rounds");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !op_pop)
        else $error("queue popped while the block is busy");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(emit_reg)))
        else $error("digest word dropped under back-pressure");

endmodule

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// Flow: an accepted byte passes through the queue register and is then loaded
// into the block; a full block then runs 64 rounds, one per cycle, plus the add.
// A finish pads up to one or two blocks, then shows four digest words.
// Bytes wait in the queue while the single round unit works on a block.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears
// the length and fill counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top level
// Byte-stream input, 64-bit digest words out, with a queue in between.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic [1:0]  m_tuser,   // word_index[1:0]
    output logic        m_tlast
);

    sha_pkg::op_t in_op;
    sha_pkg::op_t head_op;
    logic         q_full;
    logic         q_nonempty;
    logic         q_pop;

    assign in_op.kind = sha_pkg::kind_t'(s_tuser);
    assign in_op.data_byte = s_tdata;
    assign s_tready = !q_full;

    sha_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_tvalid && !q_full),
        .push_op  (in_op),
        .full     (q_full),
        .pop      (q_pop),
        .head_op  (head_op),
        .nonempty (q_nonempty)
    );

    sha_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_nonempty),
        .op        (head_op),
        .op_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_index (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
